FILE: rtl/core/sfd_pkg.sv
// ============================================================================
// sfd_pkg
// Shared types and constants of the SPI frame deframer.
// ============================================================================
`default_nettype none

package sfd_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned StatusWidth = 2;
   localparam int unsigned CsrIdxWidth = 2;

   localparam logic [ByteWidth-1:0] StartMarkerReset = 8'hF1;
   localparam logic [ByteWidth-1:0] DummyIdReset     = 8'hE1;
   localparam logic [ByteWidth-1:0] DataIdReset      = 8'hE2;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_START_MARKER = 2'd0,
      CSR_DUMMY_ID     = 2'd1,
      CSR_DATA_ID      = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_idx_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_PAYLOAD     = 2'd0,
      ST_DUMMY_EMPTY = 2'd1,
      ST_DATA_EMPTY  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PH_HUNT       = 3'd0,
      PH_ID         = 3'd1,
      PH_DUMMY_LEN  = 3'd2,
      PH_DUMMY_BODY = 3'd3,
      PH_DATA_LEN   = 3'd4,
      PH_DATA_BODY  = 3'd5
   } phase_type;

   typedef struct packed {
      logic [ByteWidth-1:0] start_marker;
      logic [ByteWidth-1:0] dummy_id;
      logic [ByteWidth-1:0] data_id;
   } cfg_type;

   typedef struct packed {
      status_type           status;
      logic [ByteWidth-1:0] payload_byte;
      logic [ByteWidth-1:0] frame_length;
      logic                 last_of_frame;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/core/sfd_csr.sv
// ============================================================================
// sfd_csr
// Configuration registers: start marker, dummy id and data id.
// ============================================================================
`default_nettype none

module sfd_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write,
   input  wire logic [sfd_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire logic [sfd_pkg::ByteWidth-1:0]   csr_data,
   output sfd_pkg::cfg_type                   cfg
);

   sfd_pkg::cfg_type cfg_ff;
   sfd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (sfd_pkg::csr_idx_type'(csr_index))
            sfd_pkg::CSR_START_MARKER: cfg_in.start_marker = csr_data;
            sfd_pkg::CSR_DUMMY_ID:     cfg_in.dummy_id     = csr_data;
            sfd_pkg::CSR_DATA_ID:      cfg_in.data_id      = csr_data;
            default:                   cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker <= sfd_pkg::StartMarkerReset;
         cfg_ff.dummy_id     <= sfd_pkg::DummyIdReset;
         cfg_ff.data_id      <= sfd_pkg::DataIdReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/core/sfd_in_reg.sv
// ============================================================================
// sfd_in_reg
// Input register: capture one received byte per request.
// ============================================================================
`default_nettype none

module sfd_in_reg (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic [sfd_pkg::ByteWidth-1:0] req_rx_byte,
   input  wire logic                        advance,
   output      logic                        byte_valid,
   output      logic [sfd_pkg::ByteWidth-1:0] byte_data
);

   logic                        valid_ff;
   logic                        valid_in;
   logic [sfd_pkg::ByteWidth-1:0] data_ff;
   logic                        load;

   assign req_ready = !valid_ff || advance;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_rx_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/sfd_deframe.sv
// ============================================================================
// sfd_deframe
// Frame state machine: phase, remaining body count and frame length.
// ============================================================================
`default_nettype none

module sfd_deframe (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire logic [sfd_pkg::ByteWidth-1:0] rx_byte,
   input  wire sfd_pkg::cfg_type            cfg,
   output      logic                        result_valid,
   output sfd_pkg::result_type              result
);

   sfd_pkg::phase_type            phase_ff;
   sfd_pkg::phase_type            phase_in;
   logic [sfd_pkg::ByteWidth-1:0] bytes_left_ff;
   logic [sfd_pkg::ByteWidth-1:0] bytes_left_in;
   logic [sfd_pkg::ByteWidth-1:0] length_ff;
   logic [sfd_pkg::ByteWidth-1:0] length_in;
   logic [sfd_pkg::ByteWidth-1:0] left_dec;

   assign left_dec = bytes_left_ff - 8'd1;

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      length_in     = length_ff;
      result_valid  = 1'b0;
      result        = '{status: sfd_pkg::ST_PAYLOAD, payload_byte: '0,
                        frame_length: '0, last_of_frame: 1'b0};
      unique case (phase_ff)
         sfd_pkg::PH_HUNT: begin
            if (rx_byte == cfg.start_marker) begin
               phase_in = sfd_pkg::PH_ID;
            end
         end
         sfd_pkg::PH_ID: begin
            if (rx_byte == cfg.dummy_id) begin
               phase_in = sfd_pkg::PH_DUMMY_LEN;
            end else if (rx_byte == cfg.data_id) begin
               phase_in = sfd_pkg::PH_DATA_LEN;
            end else begin
               phase_in = sfd_pkg::PH_HUNT;
            end
         end
         sfd_pkg::PH_DUMMY_LEN, sfd_pkg::PH_DATA_LEN: begin
            length_in     = rx_byte;
            bytes_left_in = rx_byte;
            if (rx_byte == '0) begin
               phase_in      = sfd_pkg::PH_HUNT;
               result_valid  = 1'b1;
               result.status = (phase_ff == sfd_pkg::PH_DUMMY_LEN) ?
                               sfd_pkg::ST_DUMMY_EMPTY : sfd_pkg::ST_DATA_EMPTY;
            end else begin
               phase_in = (phase_ff == sfd_pkg::PH_DUMMY_LEN) ?
                          sfd_pkg::PH_DUMMY_BODY : sfd_pkg::PH_DATA_BODY;
            end
         end
         sfd_pkg::PH_DUMMY_BODY: begin
            bytes_left_in = left_dec;
            if (left_dec == '0) begin
               phase_in = sfd_pkg::PH_HUNT;
            end
         end
         sfd_pkg::PH_DATA_BODY: begin
            bytes_left_in        = left_dec;
            result_valid         = 1'b1;
            result.payload_byte  = rx_byte;
            result.frame_length  = length_ff;
            result.last_of_frame = (left_dec == '0);
            if (left_dec == '0) begin
               phase_in = sfd_pkg::PH_HUNT;
            end
         end
         default: begin
            phase_in = sfd_pkg::PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= sfd_pkg::PH_HUNT;
         bytes_left_ff <= '0;
         length_ff     <= '0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         length_ff     <= length_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/sfd_out_reg.sv
// ============================================================================
// sfd_out_reg
// Result register: hold one response until it is taken.
// ============================================================================
`default_nettype none

module sfd_out_reg (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           load,
   input  wire sfd_pkg::result_type            result,
   output      logic                           free,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic [sfd_pkg::StatusWidth-1:0] rsp_status,
   output      logic [sfd_pkg::ByteWidth-1:0]   rsp_payload_byte,
   output      logic [sfd_pkg::ByteWidth-1:0]   rsp_frame_length,
   output      logic                           rsp_last_of_frame
);

   logic                valid_ff;
   logic                valid_in;
   sfd_pkg::result_type data_ff;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = data_ff.status;
   assign rsp_payload_byte  = data_ff.payload_byte;
   assign rsp_frame_length  = data_ff.frame_length;
   assign rsp_last_of_frame = data_ff.last_of_frame;

endmodule

`default_nettype wire

FILE: rtl/core/spi_frame_deframer_top.sv
// ============================================================================
// spi_frame_deframer_top
// Recover frames (start, id, length, body) from received SPI bytes.
// ============================================================================
//  channel   handshake               payload
//  req       req_valid / req_ready   req_rx_byte
//  rsp       rsp_valid / rsp_ready   rsp_status, rsp_payload_byte,
//                                    rsp_frame_length, rsp_last_of_frame
//  csr       csr_write               csr_index, csr_data
//
//  One request per cycle while responses are taken; a response passes
//  through the input register and then the result register.
//  Reset returns to hunting and reloads the default markers and ids.
//  A held response stalls the frame logic and, once the input register
//  is full, req_ready.
// ============================================================================
`default_nettype none

module spi_frame_deframer_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic [sfd_pkg::ByteWidth-1:0]   req_rx_byte,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [sfd_pkg::StatusWidth-1:0] rsp_status,
   output      logic [sfd_pkg::ByteWidth-1:0]   rsp_payload_byte,
   output      logic [sfd_pkg::ByteWidth-1:0]   rsp_frame_length,
   output      logic                            rsp_last_of_frame,
   input  wire logic                            csr_write,
   input  wire logic [sfd_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire logic [sfd_pkg::ByteWidth-1:0]   csr_data
);

   sfd_pkg::cfg_type              cfg;
   sfd_pkg::result_type           result;
   logic                          result_valid;
   logic                          byte_valid;
   logic [sfd_pkg::ByteWidth-1:0] byte_data;
   logic                          out_free;
   logic                          advance;

   assign advance = byte_valid && out_free;

   sfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sfd_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   sfd_deframe u_deframe (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .rx_byte      (byte_data),
      .cfg          (cfg),
      .result_valid (result_valid),
      .result       (result)
   );

   sfd_out_reg u_out_reg (
      .clock             (clock),
      .reset             (reset),
      .load              (advance && result_valid),
      .result            (result),
      .free              (out_free),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

`default_nettype wire

FILE: rtl/core/sfd_checker.sv
// ============================================================================
// sfd_checker
// Port-level checks on the response channel of the deframer.
// ============================================================================
`default_nettype none

module sfd_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [sfd_pkg::StatusWidth-1:0] rsp_status,
   input wire logic [sfd_pkg::ByteWidth-1:0]   rsp_payload_byte,
   input wire logic [sfd_pkg::ByteWidth-1:0]   rsp_frame_length,
   input wire logic                            rsp_last_of_frame
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_payload_byte) && $stable(rsp_last_of_frame))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == sfd_pkg::ST_DUMMY_EMPTY ||
                    rsp_status == sfd_pkg::ST_DATA_EMPTY) |->
      rsp_payload_byte == '0 && rsp_frame_length == '0 && !rsp_last_of_frame)
      else $error("error response carries data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sfd_pkg::ST_PAYLOAD |-> rsp_frame_length != '0)
      else $error("payload response with zero frame length");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == sfd_pkg::ST_PAYLOAD ||
                    rsp_status == sfd_pkg::ST_DUMMY_EMPTY ||
                    rsp_status == sfd_pkg::ST_DATA_EMPTY)
      else $error("undefined response status");

endmodule

bind spi_frame_deframer_top sfd_checker u_sfd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_payload_byte  (rsp_payload_byte),
   .rsp_frame_length  (rsp_frame_length),
   .rsp_last_of_frame (rsp_last_of_frame)
);

`default_nettype wire

FILE: bench/tb_spi_frame_deframer_top.sv
// ============================================================================
// tb_spi_frame_deframer_top
// Self-checking bench for the SPI frame deframer. A scoreboard tracks the
// hunt/id/length/body progress of the byte stream and queues the payload and
// empty-frame responses each request should produce. Responses are matched
// in order against the DUT. The run moves through several marker/id settings
// and through sender and receiver idle patterns.
// ============================================================================

module tb_spi_frame_deframer_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit   = 300000;
   localparam int SettleCycles = 8;
   localparam int ItemsPerRun  = 125;

   class deframe_scoreboard;
      logic [7:0]          marker;
      logic [7:0]          dummy_code;
      logic [7:0]          data_code;
      sfd_pkg::phase_type  frame_phase;
      logic [7:0]          body_remaining;
      logic [7:0]          len_byte;
      sfd_pkg::result_type due_results[$];
      int                  consumed_count;
      int                  errors;

      function new();
         marker         = sfd_pkg::StartMarkerReset;
         dummy_code     = sfd_pkg::DummyIdReset;
         data_code      = sfd_pkg::DataIdReset;
         frame_phase    = sfd_pkg::PH_HUNT;
         body_remaining = '0;
         len_byte       = '0;
         consumed_count = 0;
         errors         = 0;
      endfunction

      function void set_register(sfd_pkg::csr_idx_type idx, logic [7:0] value);
         case (idx)
            sfd_pkg::CSR_START_MARKER: marker = value;
            sfd_pkg::CSR_DUMMY_ID:     dummy_code = value;
            sfd_pkg::CSR_DATA_ID:      data_code = value;
            default: ;
         endcase
      endfunction

      function void take_byte(logic [7:0] b);
         sfd_pkg::result_type r;
         r = '0;
         consumed_count++;
         case (frame_phase)
            sfd_pkg::PH_HUNT: begin
               if (b == marker)
                  frame_phase = sfd_pkg::PH_ID;
            end
            sfd_pkg::PH_ID: begin
               if (b == dummy_code)
                  frame_phase = sfd_pkg::PH_DUMMY_LEN;
               else if (b == data_code)
                  frame_phase = sfd_pkg::PH_DATA_LEN;
               else
                  frame_phase = sfd_pkg::PH_HUNT;
            end
            sfd_pkg::PH_DUMMY_LEN, sfd_pkg::PH_DATA_LEN: begin
               len_byte       = b;
               body_remaining = b;
               if (b == 8'd0) begin
                  r.status = (frame_phase == sfd_pkg::PH_DUMMY_LEN) ?
                             sfd_pkg::ST_DUMMY_EMPTY : sfd_pkg::ST_DATA_EMPTY;
                  due_results.push_back(r);
                  frame_phase = sfd_pkg::PH_HUNT;
               end else begin
                  frame_phase = (frame_phase == sfd_pkg::PH_DUMMY_LEN) ?
                                sfd_pkg::PH_DUMMY_BODY : sfd_pkg::PH_DATA_BODY;
               end
            end
            sfd_pkg::PH_DUMMY_BODY: begin
               body_remaining = body_remaining - 8'd1;
               if (body_remaining == 8'd0)
                  frame_phase = sfd_pkg::PH_HUNT;
            end
            sfd_pkg::PH_DATA_BODY: begin
               body_remaining  = body_remaining - 8'd1;
               r.status        = sfd_pkg::ST_PAYLOAD;
               r.payload_byte  = b;
               r.frame_length  = len_byte;
               r.last_of_frame = (body_remaining == 8'd0);
               due_results.push_back(r);
               if (body_remaining == 8'd0)
                  frame_phase = sfd_pkg::PH_HUNT;
            end
            default: frame_phase = sfd_pkg::PH_HUNT;
         endcase
      endfunction

      task report(string what);
         if (errors < 50)
            $display("[%0t] mismatch: %s", $realtime, what);
         errors++;
      endtask

      task check_result(logic [1:0] st, logic [7:0] pb, logic [7:0] fl, logic last);
         sfd_pkg::result_type e;
         if (due_results.size() == 0) begin
            report($sformatf("unexpected response status %0d byte %h", st, pb));
         end else begin
            e = due_results.pop_front();
            if (st !== e.status || pb !== e.payload_byte || fl !== e.frame_length ||
                last !== e.last_of_frame)
               report($sformatf("got st %0d byte %h len %0d last %0b, want %0d %h %0d %0b",
                                st, pb, fl, last, e.status, e.payload_byte,
                                e.frame_length, e.last_of_frame));
         end
      endtask
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [sfd_pkg::ByteWidth-1:0]   req_rx_byte;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [sfd_pkg::StatusWidth-1:0] rsp_status;
   logic [sfd_pkg::ByteWidth-1:0]   rsp_payload_byte;
   logic [sfd_pkg::ByteWidth-1:0]   rsp_frame_length;
   logic                            rsp_last_of_frame;
   logic                            csr_write;
   logic [sfd_pkg::CsrIdxWidth-1:0] csr_index;
   logic [sfd_pkg::ByteWidth-1:0]   csr_data;

   deframe_scoreboard board;
   int                idle_pct;
   int                stall_pct;
   int                cycle_count;
   int                item_target;

   logic [7:0] directed_bytes [25] = '{
      8'h00, 8'hFF, sfd_pkg::DummyIdReset, sfd_pkg::DataIdReset,
      sfd_pkg::StartMarkerReset, 8'h55,
      sfd_pkg::StartMarkerReset, sfd_pkg::StartMarkerReset,
      sfd_pkg::StartMarkerReset, sfd_pkg::DummyIdReset, 8'h00,
      sfd_pkg::StartMarkerReset, sfd_pkg::DataIdReset, 8'h00,
      sfd_pkg::StartMarkerReset, sfd_pkg::DummyIdReset, 8'h02,
      sfd_pkg::StartMarkerReset, 8'hAA,
      sfd_pkg::StartMarkerReset, sfd_pkg::DataIdReset, 8'h03, 8'h00,
      sfd_pkg::StartMarkerReset, 8'hFF
   };

   spi_frame_deframer_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_status, rsp_payload_byte, rsp_frame_length, rsp_last_of_frame);
   end

   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do
         @(posedge clock);
      while (!(req_valid && req_ready));
      board.take_byte(b);
   endtask

   // hold off until every response is back and the pipeline has emptied
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.due_results.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(input sfd_pkg::csr_idx_type idx, input logic [7:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      board.set_register(idx, value);
   endtask

   task automatic send_random_burst();
      int         kind;
      int         len;
      int         body;
      logic [7:0] id;
      kind = $urandom_range(99);
      if (kind < 20) begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else if (kind < 30) begin
         send_byte(board.marker);
         send_byte(8'($urandom));
      end else begin
         id  = (kind < 50) ? board.dummy_code : board.data_code;
         len = $urandom_range(99);
         if (len < 5)
            len = 0;
         else if (len < 8)
            len = 255;
         else if (len < 15)
            len = $urandom_range(9, 254);
         else
            len = $urandom_range(1, 8);
         body = (kind >= 92 && len > 0) ? $urandom_range(0, len - 1) : len;
         send_byte(board.marker);
         send_byte(id);
         send_byte(8'(len));
         repeat (body) begin
            if (board.consumed_count < item_target)
               send_byte(($urandom_range(9) == 0) ? board.marker : 8'($urandom));
         end
      end
   endtask

   initial begin
      board       = new();
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      rsp_ready   = 1'b0;
      csr_write   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      idle_pct    = 0;
      stall_pct   = 0;
      cycle_count = 0;
      item_target = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_bytes[i])
         send_byte(directed_bytes[i]);

      for (int run = 0; run < 8; run++) begin
         drain();
         case (run % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 59; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 59; end
            default: begin idle_pct = 22; stall_pct = 22; end
         endcase
         case (run)
            1: begin
               write_csr(sfd_pkg::CSR_START_MARKER, 8'h00);
               write_csr(sfd_pkg::CSR_DUMMY_ID, 8'h00);
               write_csr(sfd_pkg::CSR_DATA_ID, 8'h00);
            end
            2: begin
               write_csr(sfd_pkg::CSR_START_MARKER, 8'hFF);
               write_csr(sfd_pkg::CSR_DUMMY_ID, 8'h00);
               write_csr(sfd_pkg::CSR_DATA_ID, 8'hFF);
            end
            4: begin
               write_csr(sfd_pkg::CSR_START_MARKER, 8'($urandom));
               write_csr(sfd_pkg::CSR_DUMMY_ID, 8'($urandom));
               write_csr(sfd_pkg::CSR_DATA_ID, board.dummy_code);
            end
            6: begin
               write_csr(sfd_pkg::CSR_UNUSED, 8'($urandom));
               write_csr(sfd_pkg::CSR_START_MARKER, sfd_pkg::StartMarkerReset);
               write_csr(sfd_pkg::CSR_DUMMY_ID, sfd_pkg::DummyIdReset);
               write_csr(sfd_pkg::CSR_DATA_ID, sfd_pkg::DataIdReset);
            end
            3, 5, 7: begin
               write_csr(sfd_pkg::CSR_START_MARKER, 8'($urandom));
               write_csr(sfd_pkg::CSR_DUMMY_ID, 8'($urandom));
               write_csr(sfd_pkg::CSR_DATA_ID, 8'($urandom));
               write_csr(sfd_pkg::CSR_UNUSED, 8'($urandom));
            end
            default: ;
         endcase
         item_target = board.consumed_count + ItemsPerRun;
         while (board.consumed_count < item_target)
            send_random_burst();
      end

      drain();
      repeat (10) @(posedge clock);
      if (board.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/sfd_pkg.sv
rtl/core/sfd_csr.sv
rtl/core/sfd_in_reg.sv
rtl/core/sfd_deframe.sv
rtl/core/sfd_out_reg.sv
rtl/core/spi_frame_deframer_top.sv
rtl/core/sfd_checker.sv
bench/tb_spi_frame_deframer_top.sv
